// ----- hdl/cml_pkg.sv -----
`default_nettype none
package cml_pkg;

  localparam int unsigned PROB_W  = 17;
  localparam int unsigned ACC_W   = 26;
  localparam int unsigned MAG_W   = 21;
  localparam int unsigned FRAC_W  = 24;

  localparam logic [PROB_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [MAG_W-1:0]  FLOOR_MAG = 21'd1509022;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -26'sd33554432;

  localparam logic [1:0] KIND_PROB  = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_OBS   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROB_W-1:0] prob;
  } lu_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] mag;
  } lu_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/cml_ram.sv -----
`default_nettype none
module cml_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                   clk_i,
  input  wire                                   we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                      wdata_i,
  input  wire                                   re_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cml_log_unit.sv -----
`default_nettype none
module cml_log_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cml_pkg::lu_req_t  req_i,
  output cml_pkg::lu_rsp_t  rsp_o
);
  import cml_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_SQ   = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [30:0]       m_q, m_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [4:0]        e_q, e_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              done_q, done_d;

  logic [PROB_W-1:0] p_clamp;
  logic [4:0]        e_new;
  logic [61:0]       sq;
  logic [31:0]       sq_sh;
  logic [28:0]       mag_q24;
  logic [60:0]       prod;

  always_comb begin
    p_clamp = (req_i.prob > ONE_Q16) ? ONE_Q16 : req_i.prob;
    e_new   = 5'd0;
    for (int i = 0; i < PROB_W; i++) begin
      if (p_clamp[i]) begin
        e_new = 5'(i);
      end
    end
    sq      = {31'b0, m_q} * {31'b0, m_q};
    sq_sh   = sq[61:30];
    mag_q24 = {5'd16 - e_q, 24'b0} - {5'b0, frac_q};
    prod    = {32'b0, mag_q24} * {29'b0, LN2_Q32} + (61'd1 << 39);
  end

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    frac_d  = frac_q;
    e_d     = e_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          if (req_i.prob == '0) begin
            mag_d  = FLOOR_MAG;
            done_d = 1'b1;
          end else begin
            e_d     = e_new;
            m_d     = 31'({14'b0, p_clamp} << (5'd30 - e_new));
            frac_d  = '0;
            cnt_d   = '0;
            state_d = L_SQ;
          end
        end
      end
      L_SQ: begin
        // one fraction bit of log2 per squaring
        if (sq_sh[31]) begin
          m_d    = sq_sh[31:1];
          frac_d = {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          m_d    = sq_sh[30:0];
          frac_d = {frac_q[FRAC_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(FRAC_W - 1)) begin
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        mag_d   = prod[60:40];
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    frac_q <= frac_d;
    e_q    <= e_d;
    cnt_q  <= cnt_d;
    mag_q  <= mag_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mag  = mag_q;

endmodule
`default_nettype wire

// ----- hdl/categorical_mixture_loglik.sv -----
// channel   dir  tdata (low bit up)                                   tuser  tlast
// s_axis    in   feature 4, category 8, component 3, probability 17,  kind   last
//                count 5, observed 1, zero pad to 40
// m_axis    out  comp_index 3, log_likelihood 26, zero pad to 32      -      last_result
//
// table words (kinds 0 and 1) are written straight from the input while the block is idle
// an observed feature word is worked one component at a time: the shared log unit does
// 24 squaring steps and one scaling multiply between accumulator read and write-back
// a last word then emits COMPONENTS results, one accumulator read each, held by output stalls
// reset clears the accumulators at once through per-entry valid bits; no clearing pass
`default_nettype none
module categorical_mixture_loglik #(
  parameter int unsigned MAX_FEATURES   = 16,
  parameter int unsigned MAX_CATEGORIES = 16,
  parameter int unsigned COMPONENTS     = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,  // feature, category, component, probability, count, observed
  input  wire  [1:0]  s_axis_tuser_i,  // kind
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // comp_index, log_likelihood
  output logic        m_axis_tlast_o
);
  import cml_pkg::*;

  localparam int unsigned TBL_D  = MAX_FEATURES * MAX_CATEGORIES * COMPONENTS;
  localparam int unsigned TBL_AW = TBL_D > 1 ? $clog2(TBL_D) : 1;
  localparam int unsigned KW     = COMPONENTS > 1 ? $clog2(COMPONENTS) : 1;
  localparam int unsigned FW     = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_LOG  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EOUT = 3'd6;

  logic [3:0]        in_feature;
  logic [7:0]        in_category;
  logic [2:0]        in_component;
  logic [PROB_W-1:0] in_prob;
  logic [4:0]        in_count;
  logic              in_observed;
  logic              acc_in;

  assign in_feature   = s_axis_tdata_i[3:0];
  assign in_category  = s_axis_tdata_i[11:4];
  assign in_component = s_axis_tdata_i[14:12];
  assign in_prob      = s_axis_tdata_i[31:15];
  assign in_count     = s_axis_tdata_i[36:32];
  assign in_observed  = s_axis_tdata_i[37];

  logic [2:0]        state_q, state_d;
  logic [KW-1:0]     k_q, k_d;
  logic [TBL_AW-1:0] base_q, base_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic [COMPONENTS-1:0] acc_vld_q, acc_vld_d;
  logic              out_valid_q, out_valid_d;
  logic [KW-1:0]     out_k_q, out_k_d;
  logic [ACC_W-1:0]  out_ll_q, out_ll_d;
  logic              out_last_q, out_last_d;

  logic [4:0]  limit_q [MAX_FEATURES];
  logic [7:0]  feat_ext;
  logic [31:0] base_full;
  logic        feat_ok;
  logic        cat_ok;

  logic              prob_we, prob_re;
  logic [TBL_AW-1:0] prob_waddr;
  logic [PROB_W-1:0] prob_rdata;
  logic              acc_we, acc_re;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata;
  logic signed [ACC_W-1:0] acc_cur;
  logic signed [ACC_W:0]   acc_sum;

  lu_req_t lu_req;
  lu_rsp_t lu_rsp;

  assign acc_in    = s_axis_tvalid_i && s_axis_tready_o;
  assign feat_ext  = {4'b0, in_feature};
  assign feat_ok   = 32'(in_feature) < MAX_FEATURES;
  assign base_full = (32'(in_feature) * MAX_CATEGORIES + 32'(in_category)) * COMPONENTS;
  assign cat_ok    = feat_ok && (32'(in_category) < MAX_CATEGORIES)
                     && (in_category < {3'b0, limit_q[feat_ext[FW-1:0]]});

  assign prob_we    = acc_in && s_axis_tuser_i == KIND_PROB && feat_ok
                      && 32'(in_category) < MAX_CATEGORIES && 32'(in_component) < COMPONENTS;
  assign prob_waddr = TBL_AW'(base_full + 32'(in_component));

  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tuser_i == KIND_COUNT && feat_ok) begin
      limit_q[feat_ext[FW-1:0]] <= in_count;
    end
  end

  cml_ram #(.WIDTH(PROB_W), .DEPTH(TBL_D)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (prob_we),
    .waddr_i (prob_waddr),
    .wdata_i (in_prob),
    .re_i    (prob_re),
    .raddr_i (base_q + TBL_AW'(k_q)),
    .rdata_o (prob_rdata)
  );

  cml_ram #(.WIDTH(ACC_W), .DEPTH(COMPONENTS)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (k_q),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (k_q),
    .rdata_o (acc_rdata)
  );

  cml_log_unit u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lu_req),
    .rsp_o  (lu_rsp)
  );

  // an entry never written since reset or emission reads as zero
  assign acc_cur = acc_vld_q[k_q] ? signed'(acc_rdata) : '0;
  assign acc_sum = {acc_cur[ACC_W-1], acc_cur} - signed'({1'b0, ACC_W'(lu_rsp.mag)});

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    base_d      = base_q;
    valid_d     = valid_q;
    last_d      = last_q;
    acc_vld_d   = acc_vld_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_k_d     = out_k_q;
    out_ll_d    = out_ll_q;
    out_last_d  = out_last_q;
    prob_re     = 1'b0;
    acc_re      = 1'b0;
    acc_we      = 1'b0;
    acc_wdata   = '0;
    lu_req.start = 1'b0;
    lu_req.prob  = valid_q ? prob_rdata : '0;
    case (state_q)
      S_IDLE: begin
        if (acc_in && s_axis_tuser_i == KIND_OBS) begin
          base_d  = TBL_AW'(base_full);
          valid_d = cat_ok;
          last_d  = s_axis_tlast_i;
          k_d     = '0;
          if (in_observed && feat_ok) begin
            state_d = S_RD;
          end else if (s_axis_tlast_i) begin
            state_d = S_ERD;
          end
        end
      end
      S_RD: begin
        prob_re = 1'b1;
        acc_re  = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        // invalid category goes in as probability zero, which gives the floor term
        lu_req.start = 1'b1;
        state_d      = S_LOG;
      end
      S_LOG: begin
        if (lu_rsp.done) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        acc_we         = 1'b1;
        acc_wdata      = (acc_sum < 27'(ACC_MIN)) ? ACC_MIN : acc_sum[ACC_W-1:0];
        acc_vld_d[k_q] = 1'b1;
        if (k_q == KW'(COMPONENTS - 1)) begin
          k_d     = '0;
          state_d = last_q ? S_ERD : S_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_ERD: begin
        acc_re  = 1'b1;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (!out_valid_q) begin
          out_valid_d    = 1'b1;
          out_k_d        = k_q;
          out_ll_d       = acc_vld_q[k_q] ? acc_rdata : '0;
          out_last_d     = k_q == KW'(COMPONENTS - 1);
          acc_vld_d[k_q] = 1'b0;
          if (k_q == KW'(COMPONENTS - 1)) begin
            k_d     = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      acc_vld_q   <= acc_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    valid_q    <= valid_d;
    last_q     <= last_d;
    out_k_q    <= out_k_d;
    out_ll_q   <= out_ll_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b0, out_ll_q, 3'((8)'(out_k_q))};
  assign m_axis_tlast_o  = out_last_q;

  a_lu_start_only_when_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lu_req.start |-> state_q == S_WAIT) else $error("log unit started outside wait state");

  a_lu_done_only_in_log : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lu_rsp.done |-> state_q == S_LOG) else $error("log unit result outside log state");

  a_emit_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EOUT && !out_valid_q) |=> out_valid_q)
    else $error("emission did not load output register");

  a_idle_accs_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_EOUT && state_q == S_IDLE) |-> acc_vld_q == '0)
    else $error("accumulators not cleared after emission");

endmodule
`default_nettype wire

// ----- dv/cml_checker.sv -----
`timescale 1ns / 1ps
module cml_checker
  import cml_pkg::*;
#(
  parameter int unsigned MAX_FEATURES   = 16,
  parameter int unsigned MAX_CATEGORIES = 16,
  parameter int unsigned COMPONENTS     = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_valid_i,
  input  wire         s_ready_i,
  input  wire  [39:0] s_data_i,
  input  wire  [1:0]  s_user_i,
  input  wire         s_last_i,
  input  wire         m_valid_i,
  input  wire         m_ready_i,
  input  wire  [31:0] m_data_i,
  input  wire         m_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [2:0]       comp;
    logic [ACC_W-1:0] loglik;
    logic             last;
  } loglik_t;

  logic [PROB_W-1:0] prob_mem [MAX_FEATURES*MAX_CATEGORIES*COMPONENTS];
  logic [4:0]        limit_mem [MAX_FEATURES];
  longint            acc_sum [COMPONENTS];
  loglik_t           loglik_q [$];

  // q.16 magnitude of -ln(p / 2^16), squaring method for log2
  function automatic logic [MAG_W-1:0] log_mag(logic [PROB_W-1:0] p_in);
    logic [63:0] m;
    logic [63:0] mag;
    logic [31:0] frac;
    int unsigned e;
    logic [PROB_W-1:0] p;
    p = p_in;
    frac = '0;
    e = 0;
    if (p == '0) return FLOOR_MAG;
    if (p > ONE_Q16) p = ONE_Q16;
    while ((p >> (e + 1)) != 0) e++;
    m = 64'(p) << (30 - e);
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    mag = (64'(16 - e) << 24) - 64'(frac);
    mag = (mag * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
    return mag[MAG_W-1:0];
  endfunction

  task automatic note_mismatch(string what, loglik_t want, loglik_t got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch %s: expected comp %0d ll %0d last %0b, got comp %0d ll %0d last %0b",
               what, want.comp, $signed(want.loglik), want.last,
               got.comp, $signed(got.loglik), got.last);
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = loglik_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COMPONENTS; k++) acc_sum[k] = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        logic [3:0] feat;
        logic [7:0] cat;
        logic [2:0] comp;
        logic       obs;
        logic       good;
        longint     s;
        loglik_t    r;
        feat = s_data_i[3:0];
        cat  = s_data_i[11:4];
        comp = s_data_i[14:12];
        obs  = s_data_i[37];
        case (s_user_i)
          KIND_PROB: begin
            if (cat < MAX_CATEGORIES)
              prob_mem[(feat*MAX_CATEGORIES + cat)*COMPONENTS + comp] = s_data_i[31:15];
          end
          KIND_COUNT: begin
            limit_mem[feat] = s_data_i[36:32];
          end
          KIND_OBS: begin
            if (obs) begin
              good = (cat < limit_mem[feat]) && (cat < MAX_CATEGORIES);
              for (int k = 0; k < COMPONENTS; k++) begin
                s = acc_sum[k] - longint'(good ?
                    log_mag(prob_mem[(feat*MAX_CATEGORIES + cat)*COMPONENTS + k]) : FLOOR_MAG);
                if (s < longint'(ACC_MIN)) s = longint'(ACC_MIN);
                acc_sum[k] = s;
              end
            end
            if (s_last_i) begin
              for (int k = 0; k < COMPONENTS; k++) begin
                r.comp = k[2:0];
                r.loglik = acc_sum[k][ACC_W-1:0];
                r.last = (k == COMPONENTS - 1);
                loglik_q.push_back(r);
                acc_sum[k] = 0;
              end
            end
          end
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        loglik_t got;
        loglik_t want;
        got.comp = m_data_i[2:0];
        got.loglik = m_data_i[28:3];
        got.last = m_last_i;
        checked_o++;
        if (loglik_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected word", want, got);
        end else begin
          want = loglik_q.pop_front();
          if (got.comp != want.comp) note_mismatch("comp_index", want, got);
          else if (got.loglik != want.loglik) note_mismatch("log_likelihood", want, got);
          else if (got.last != want.last) note_mismatch("last_result", want, got);
        end
      end
    end
  end

endmodule

// ----- dv/tb_categorical_mixture_loglik.sv -----
`timescale 1ns / 1ps
module tb_categorical_mixture_loglik;
  import cml_pkg::*;

  // kind code that the block ignores
  localparam logic [1:0] KIND_BAD = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;  // feature, category, component, probability, count, observed
  logic [1:0]  s_axis_tuser_i = '0;  // kind
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;       // comp_index, log_likelihood
  logic        m_axis_tlast_o;

  int fail_count;
  int pending;
  int checked;
  int words_sent = 0;
  int obs_count = 0;
  bit calm = 1'b0;
  logic [4:0] cat_lim [16];

  always #6 clk_i = ~clk_i;

  categorical_mixture_loglik dut (.*);

  cml_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o), .s_data_i(s_axis_tdata_i),
    .s_user_i(s_axis_tuser_i), .s_last_i(s_axis_tlast_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i), .m_data_i(m_axis_tdata_o),
    .m_last_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd1;
      2: return ONE_Q16;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    int g;
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else begin
      g = pick_gap();
      m_axis_tready_i <= (g == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  task automatic push_word(logic [1:0] kind, logic [3:0] feat, logic [7:0] cat,
                           logic [2:0] comp, logic [16:0] prob, logic [4:0] cnt,
                           logic obs, logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tlast_i <= last;
    s_axis_tdata_i <= {2'b00, obs, cnt, prob, comp, cat, feat};
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
    if (kind == KIND_OBS && last) obs_count++;
  endtask

  task automatic set_count(logic [3:0] feat, logic [4:0] cnt);
    cat_lim[feat] = cnt;
    push_word(KIND_COUNT, feat, 8'($urandom), 3'($urandom), 17'($urandom), cnt,
              1'($urandom), 1'($urandom));
  endtask

  task automatic observe(logic [3:0] feat, logic [7:0] cat, logic obs, logic last);
    push_word(KIND_OBS, feat, cat, 3'($urandom), 17'($urandom), 5'($urandom), obs, last);
  endtask

  initial begin
    #(12ns * 1500000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    int nf;
    int lim;
    logic [3:0] f;
    logic [7:0] c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the rows in use: features 0 to 3, categories 0 to 3
    // other features keep a zero count, so their observations give the floor term
    calm = 1'b1;
    for (int i = 0; i < 16; i++)
      set_count(4'(i), (i < 4) ? 5'($urandom_range(1, 4)) : 5'd0);
    for (int f0 = 0; f0 < 4; f0++)
      for (int c0 = 0; c0 < 4; c0++)
        for (int k = 0; k < 8; k++)
          push_word(KIND_PROB, 4'(f0), 8'(c0), 3'(k), pick_prob(), 5'($urandom), 1'b0,
                    1'($urandom));
    calm = 1'b0;

    // directed: extremes of probability, count limits, missing and saturation
    set_count(4'd0, 5'd4);
    set_count(4'd1, 5'd0);
    set_count(4'd2, 5'd31);
    push_word(KIND_PROB, 4'd0, 8'd0, 3'd0, 17'd0, 5'd0, 1'b0, 1'b1);
    push_word(KIND_PROB, 4'd0, 8'd0, 3'd1, ONE_Q16, 5'd0, 1'b0, 1'b0);
    push_word(KIND_PROB, 4'd0, 8'd0, 3'd2, 17'd1, 5'd0, 1'b0, 1'b0);
    push_word(KIND_PROB, 4'd0, 8'd0, 3'd3, 17'h1ffff, 5'd31, 1'b1, 1'b0);
    push_word(KIND_PROB, 4'd15, 8'd255, 3'd7, 17'd5, 5'd0, 1'b0, 1'b0);
    observe(4'd0, 8'd0, 1'b1, 1'b0);
    observe(4'd0, 8'd3, 1'b1, 1'b0);
    observe(4'd0, 8'd4, 1'b1, 1'b1);
    observe(4'd1, 8'd0, 1'b1, 1'b1);
    observe(4'd2, 8'd16, 1'b1, 1'b1);
    set_count(4'd2, 5'd4);
    observe(4'd15, 8'd255, 1'b1, 1'b0);
    observe(4'd3, 8'd0, 1'b0, 1'b1);
    push_word(KIND_BAD, 4'd0, 8'd0, 3'd0, 17'd0, 5'd0, 1'b1, 1'b1);
    observe(4'd0, 8'd0, 1'b0, 1'b1);
    // floor terms until the accumulators pin at the low bound
    for (int i = 0; i < 24; i++) observe(4'(i), 8'd200, 1'b1, i == 23);

    // random: mostly well-formed observations, some table rewrites and noise
    n = 0;
    while (n < 260) begin
      if (n >= 200 && n < 210) begin
        wait (pending == 0);
        @(posedge clk_i);
      end
      if ($urandom_range(0, 40) == 0) calm = ~calm;
      case ($urandom_range(0, 19))
        0, 1: begin
          push_word(KIND_PROB, 4'($urandom), 8'($urandom_range(0, 20)), 3'($urandom),
                    pick_prob(), 5'($urandom), 1'($urandom), 1'($urandom));
          n++;
        end
        2: begin
          f = 4'($urandom);
          set_count(f, (f < 4'd4) ? 5'($urandom_range(0, 4)) : 5'd0);
          n++;
        end
        3: begin
          push_word(KIND_BAD, 4'($urandom), 8'($urandom), 3'($urandom), 17'($urandom),
                    5'($urandom), 1'($urandom), 1'($urandom));
        end
        default: begin
          nf = $urandom_range(1, 5);
          for (int i = 0; i < nf; i++) begin
            f = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            lim = cat_lim[f];
            if (lim > 0 && $urandom_range(0, 4) != 0) c = 8'($urandom_range(0, lim - 1));
            else c = 8'($urandom);
            observe(f, c, $urandom_range(0, 7) != 0, i == nf - 1);
            n++;
          end
        end
      endcase
    end

    s_axis_tvalid_i <= 1'b0;
    fork
      wait (pending == 0);
      repeat (200000) @(posedge clk_i);
    join_any
    disable fork;
    repeat (400) @(posedge clk_i);
    $display("sent %0d words covering %0d observations, checked %0d result words",
             words_sent, obs_count, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
